// ===== design/lst_pkg.sv =====
// lst_pkg: shared constants for the learned sensor table
// table depth, id, zone and type widths, derived widths, command codes and result status codes; no dependencies
package lst_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ID_W        = 24;
  localparam int ZONE_W      = 5;
  localparam int STATUS_W    = 3;
  localparam int OUT_IDX_W   = 4;
  localparam int TYPE_W      = 4;

  localparam logic [ZONE_W-1:0] ZONE_MAX = 5'h1F;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_LEARN  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LEARNED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

endpackage

// ===== design/learned_sensor_table_unit.sv =====
// learned_sensor_table_unit: table of learned sensor ids with zone numbers
// depends on lst_pkg for depth, widths and status codes
//
// One transaction is accepted at a time. A lookup or learn walks the valid
// entries through one id comparator, one entry per cycle from a registered
// table read. A miss or a new learn shows its result once every stored
// entry has been compared; a match ends the walk early, and a learn on a
// full table skips the walk. A finished result moves into an output
// register once that register is free, and the unit is ready again in the
// same cycle that its result appears there. The next item may be accepted
// while the result waits in the output register. The table needs no
// clearing after reset: only entries below the entry count are ever read.
module learned_sensor_table_unit
  import lst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [ID_W-1:0]      in_sensor_id,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [OUT_IDX_W-1:0] out_entry_index,
  output logic [ZONE_W-1:0]    out_zone_number
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [ID_W-1:0]   id_mem   [TABLE_DEPTH];
  logic [ZONE_W-1:0] zone_mem [TABLE_DEPTH];

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    entry_count_r, entry_count_nxt;
  logic [CNT_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic                cmd_r;
  logic [ID_W-1:0]     id_r;
  logic [ID_W-1:0]     rd_id_r;
  logic [ZONE_W-1:0]   rd_zone_r;
  logic [IDX_W-1:0]    rd_idx_r;
  logic                rd_vld_r, rd_vld_nxt;
  logic [ZONE_W-1:0]   zone_acc_r, zone_acc_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [IDX_W-1:0]    res_idx_r, res_idx_nxt;
  logic [ZONE_W-1:0]   res_zone_r, res_zone_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [OUT_IDX_W-1:0] out_idx_r;
  logic [ZONE_W-1:0]   out_zone_r;

  logic in_fire, out_load, mem_rd_en, mem_wr_en, id_hit, type_hit, scan_end;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign mem_rd_en = (state_r == S_SCAN) && (rd_ptr_r < entry_count_r);
  assign id_hit    = rd_vld_r && (rd_id_r == id_r);
  assign type_hit  = rd_vld_r && (rd_id_r[ID_W-1 -: TYPE_W] == id_r[ID_W-1 -: TYPE_W]);
  assign scan_end  = (state_r == S_SCAN) && !rd_vld_r && (rd_ptr_r == entry_count_r);
  assign mem_wr_en = scan_end && (cmd_r == CMD_LEARN);

  // table storage with registered read
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      id_mem[entry_count_r[IDX_W-1:0]]   <= id_r;
      zone_mem[entry_count_r[IDX_W-1:0]] <= zone_acc_r;
    end
    if (mem_rd_en) begin
      rd_id_r   <= id_mem[rd_ptr_r[IDX_W-1:0]];
      rd_zone_r <= zone_mem[rd_ptr_r[IDX_W-1:0]];
      rd_idx_r  <= rd_ptr_r[IDX_W-1:0];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    entry_count_nxt = entry_count_r;
    rd_ptr_nxt      = rd_ptr_r;
    rd_vld_nxt      = mem_rd_en;
    zone_acc_nxt    = zone_acc_r;
    res_status_nxt  = res_status_r;
    res_idx_nxt     = res_idx_r;
    res_zone_nxt    = res_zone_r;
    out_valid_nxt   = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          rd_ptr_nxt   = '0;
          zone_acc_nxt = ZONE_W'(1);
          if (in_cmd == CMD_LEARN && entry_count_r >= CNT_W'(TABLE_DEPTH)) begin
            res_status_nxt = ST_FULL;
            res_idx_nxt    = '0;
            res_zone_nxt   = '0;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (mem_rd_en) begin
          rd_ptr_nxt = rd_ptr_r + 1'b1;
        end
        if (id_hit) begin
          rd_vld_nxt = 1'b0;
          state_nxt  = S_DONE;
          if (cmd_r == CMD_LOOKUP) begin
            res_status_nxt = ST_FOUND;
            res_idx_nxt    = rd_idx_r;
            res_zone_nxt   = rd_zone_r;
          end else begin
            res_status_nxt = ST_DUPLICATE;
            res_idx_nxt    = '0;
            res_zone_nxt   = '0;
          end
        end else if (type_hit && zone_acc_r != ZONE_MAX) begin
          zone_acc_nxt = zone_acc_r + 1'b1;
        end
        if (scan_end) begin
          state_nxt = S_DONE;
          if (cmd_r == CMD_LOOKUP) begin
            res_status_nxt = ST_NOT_FOUND;
            res_idx_nxt    = '0;
            res_zone_nxt   = '0;
          end else begin
            res_status_nxt  = ST_LEARNED;
            res_idx_nxt     = entry_count_r[IDX_W-1:0];
            res_zone_nxt    = zone_acc_r;
            entry_count_nxt = entry_count_r + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= '0;
      rd_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      entry_count_r <= entry_count_nxt;
      rd_vld_r      <= rd_vld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_ptr_r     <= rd_ptr_nxt;
    zone_acc_r   <= zone_acc_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_zone_r   <= res_zone_nxt;
    if (in_fire) begin
      cmd_r <= in_cmd;
      id_r  <= in_sensor_id;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_idx_r    <= OUT_IDX_W'(res_idx_r);
      out_zone_r   <= res_zone_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_index = out_idx_r;
  assign out_zone_number = out_zone_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> rd_ptr_r <= entry_count_r)
    else $error("read pointer past entry count");

  a_learn_grows: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |=> entry_count_r == $past(entry_count_r) + 1'b1)
    else $error("learn did not grow the table");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> state_r == S_DONE)
    else $error("result overwrote a pending transaction");

  a_no_write_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> entry_count_r < CNT_W'(TABLE_DEPTH))
    else $error("write into a full table");

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for learned_sensor_table_unit
// sends lookup and learn transactions and checks each result against a local
// copy of the sensor table; depends on lst_pkg and the unit under test
module tb
  import lst_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int END_WAIT       = 40;
  localparam int LONG_HOLD      = 400;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] index;
    logic [ZONE_W-1:0]    zone;
  } table_result_t;

  typedef enum {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                 clk;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_cmd       = CMD_LOOKUP;
  logic [ID_W-1:0]      in_sensor_id = '0;
  logic                 out_ready    = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [OUT_IDX_W-1:0] out_entry_index;
  logic [ZONE_W-1:0]    out_zone_number;

  logic [ID_W-1:0]   known_ids   [TABLE_DEPTH];
  logic [ZONE_W-1:0] known_zones [TABLE_DEPTH];
  int                known_count = 0;
  table_result_t     pending_results[$];
  int                mismatch_count = 0;
  int                stall_count = 0;
  int                burst_left = 0;
  int                hold_req = 0;

  learned_sensor_table_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_sensor_id    (in_sensor_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_zone_number (out_zone_number)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic table_result_t table_predict(logic cmd, logic [ID_W-1:0] id);
    table_result_t r;
    int unsigned   zone;
    r = '{ST_NOT_FOUND, '0, '0};
    if (cmd == CMD_LOOKUP) begin
      for (int i = 0; i < known_count; i++) begin
        if (known_ids[i] == id) begin
          r = '{ST_FOUND, OUT_IDX_W'(i), known_zones[i]};
          return r;
        end
      end
      return r;
    end
    if (known_count >= TABLE_DEPTH) begin
      r = '{ST_FULL, '0, '0};
      return r;
    end
    zone = 1;
    for (int i = 0; i < known_count; i++) begin
      if (known_ids[i] == id) begin
        r = '{ST_DUPLICATE, '0, '0};
        return r;
      end
      if (known_ids[i][ID_W-1 -: TYPE_W] == id[ID_W-1 -: TYPE_W]) zone++;
    end
    if (zone > ZONE_MAX) zone = ZONE_MAX;
    known_ids[known_count]   = id;
    known_zones[known_count] = ZONE_W'(zone);
    r = '{ST_LEARNED, OUT_IDX_W'(known_count), ZONE_W'(zone)};
    known_count++;
    return r;
  endfunction

  task automatic flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("error at %0t: %s", $time, msg);
  endtask

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin : result_check
    table_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          flag_error($sformatf("unexpected result status %0d index %0d zone %0d",
                               out_status, out_entry_index, out_zone_number));
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status || out_entry_index !== want.index ||
              out_zone_number !== want.zone) begin
            flag_error($sformatf({"expected status %0d index %0d zone %0d, ",
                                  "got status %0d index %0d zone %0d"},
                                 want.status, want.index, want.zone,
                                 out_status, out_entry_index, out_zone_number));
          end
        end
      end
      if (in_valid && in_ready) pending_results.push_back(table_predict(in_cmd, in_sensor_id));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_count <= 0;
    end else if (stall_count >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("learned_sensor_table_unit: mismatch");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin : ready_pattern
    rx_mode_t mode;
    int       left;
    int       phase;
    int       hold_left;
    int       hold_seen;
    mode      = RX_ALWAYS;
    left      = 0;
    phase     = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(16, 200);
        end
        left--;
        phase++;
        case (mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
          default:   out_ready <= (phase % 5 < 2);
        endcase
      end
    end
  end

  task automatic send_item(logic cmd, logic [ID_W-1:0] id);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_sensor_id <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_lookup();
    send_item(CMD_LOOKUP, 24'h000000);
    send_item(CMD_LOOKUP, 24'hFFFFFF);
  endtask

  task automatic test_first_learns();
    send_item(CMD_LEARN, 24'h000000);
    send_item(CMD_LEARN, 24'hFFFFFF);
    send_item(CMD_LEARN, 24'h000000);
    send_item(CMD_LOOKUP, 24'hFFFFFF);
    send_item(CMD_LOOKUP, 24'h000001);
    send_item(CMD_LEARN, 24'h0FFFFF);
    send_item(CMD_LEARN, 24'hF00000);
  endtask

  // same device type throughout, so the zone climbs with each entry
  task automatic test_fill_table();
    for (int k = 0; k < TABLE_DEPTH - 4; k++) begin
      send_item(CMD_LEARN, {4'h0, 20'((k + 1) * 20'h10000 + 20'h05A5A)});
    end
  endtask

  // full check wins over the duplicate check
  task automatic test_full_table();
    send_item(CMD_LEARN, 24'h123456);
    send_item(CMD_LEARN, 24'hFFFFFF);
    send_item(CMD_LOOKUP, known_ids[TABLE_DEPTH-1]);
    send_item(CMD_LOOKUP, 24'h0FFFFF);
  endtask

  task automatic test_random_traffic(int count);
    logic            cmd;
    logic [ID_W-1:0] id;
    int              pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      cmd  = ($urandom_range(0, 4) == 0) ? CMD_LEARN : CMD_LOOKUP;
      id   = known_ids[$urandom_range(0, known_count - 1)];
      if (pick >= 50 && pick < 70) id = id ^ (24'h1 << $urandom_range(0, ID_W - 1));
      else if (pick >= 70 && pick < 80) id = {id[ID_W-1 -: TYPE_W], 20'($urandom)};
      else if (pick >= 80) id = ID_W'($urandom);
      send_item(cmd, id);
    end
  endtask

  // receiver stops for a long stretch while transactions keep coming
  task automatic test_backpressure();
    hold_req++;
    test_random_traffic(30);
    drain_results();
  endtask

  initial begin : run
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_lookup();
    test_first_learns();
    test_fill_table();
    test_full_table();
    test_random_traffic(800);
    drain_results();
    test_backpressure();
    test_random_traffic(790);
    drain_results();
    repeat (END_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("learned_sensor_table_unit: match");
    end else begin
      $display("learned_sensor_table_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/lst_pkg.sv
design/learned_sensor_table_unit.sv
tb/tb.sv
